FILE: hw/rtl/cadf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cadf_pkg;

	localparam logic [1:0] OP_CLASSIFY = 2'd0;
	localparam logic [1:0] OP_WRITE    = 2'd1;
	localparam logic [1:0] OP_READ     = 2'd2;
	localparam logic [1:0] OP_NONE     = 2'd3;

	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [15:0] ETH_IPV6 = 16'h86DD;

	localparam logic [7:0] LEN_V4 = 8'd32;
	localparam logic [7:0] LEN_V6 = 8'd128;

	localparam logic [1:0] MATCH_NONE  = 2'd0;
	localparam logic [1:0] MATCH_ALLOW = 2'd1;
	localparam logic [1:0] MATCH_DENY  = 2'd2;

	localparam logic [1:0] ACT_DROP = 2'd1;

	// request after front-end decode
	typedef struct packed {
		logic [1:0]  op;
		logic        is_ip;
		logic        fam;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [15:0] pkt_len;
		logic [5:0]  idx;
		logic        idx_ok;
		logic        list;
		logic        rfam;
		logic [7:0]  plen;
		logic [15:0] prio;
		logic [1:0]  act;
		logic        rvalid;
	} req_t;

	// one rule table entry
	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        valid;
		logic        list;
		logic        fam;
		logic [7:0]  plen;
		logic [15:0] prio;
		logic [1:0]  act;
	} rule_t;

	typedef struct packed {
		logic        verdict;
		logic [1:0]  matched;
		logic [5:0]  hit_index;
		logic [63:0] count_packets;
		logic [63:0] count_bytes;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_PICK,
		ST_COUNT,
		ST_READ,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/cadf_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cadf_front #(
	parameter int RULES = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [1:0]   opcode,
	input  wire logic [15:0]  ethertype,
	input  wire logic [63:0]  addr_hi,
	input  wire logic [63:0]  addr_lo,
	input  wire logic [15:0]  pkt_len,
	input  wire logic [5:0]   rule_index,
	input  wire logic         rule_list,
	input  wire logic         rule_family,
	input  wire logic [7:0]   rule_prefix_len,
	input  wire logic [15:0]  rule_priority,
	input  wire logic [1:0]   rule_action,
	input  wire logic         rule_valid,
	output logic              q_valid,
	output cadf_pkg::req_t    q_item,
	input  wire logic         q_pop
);

	cadf_pkg::req_t req;
	cadf_pkg::req_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic [7:0]     cap;
	logic           v4_pkt;

	// classify: family, IPv4 address masking, prefix length saturation
	always_comb begin
		cap          = rule_family ? cadf_pkg::LEN_V6 : cadf_pkg::LEN_V4;
		req          = '0;
		req.op       = opcode;
		req.is_ip    = (ethertype == cadf_pkg::ETH_IPV4) || (ethertype == cadf_pkg::ETH_IPV6);
		req.fam      = (ethertype == cadf_pkg::ETH_IPV6);
		// only a classify address that is not IPv6 is cut to 32 bits; rule writes keep the full prefix
		v4_pkt       = (opcode == cadf_pkg::OP_CLASSIFY) && !req.fam;
		req.addr_hi  = v4_pkt ? {addr_hi[63:32], 32'd0} : addr_hi;
		req.addr_lo  = v4_pkt ? 64'd0 : addr_lo;
		req.pkt_len  = pkt_len;
		req.idx      = rule_index;
		req.idx_ok   = (32'(rule_index) < RULES);
		req.list     = rule_list;
		req.rfam     = rule_family;
		req.plen     = (rule_prefix_len > cap) ? cap : rule_prefix_len;
		req.prio     = rule_priority;
		req.act      = rule_action;
		req.rvalid   = rule_valid;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop && q_valid) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/cadf_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cadf_back #(
	parameter int RULES = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire cadf_pkg::req_t q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output cadf_pkg::res_t      out_res
);

	localparam int AW = (RULES > 1) ? $clog2(RULES) : 1;
	localparam logic [AW-1:0] LAST = AW'(RULES - 1);

	cadf_pkg::state_t state_q, st_d;
	cadf_pkg::req_t   cur_q;
	cadf_pkg::res_t   res_q, out_q;
	logic             out_valid_q;

	cadf_pkg::rule_t  rule_mem [RULES];
	logic [63:0]      pk_mem [RULES];
	logic [63:0]      by_mem [RULES];
	logic [RULES-1:0] written_q;

	logic [AW-1:0]    scan_q;
	logic             vld_s1;
	logic [AW-1:0]    idx_s1;
	cadf_pkg::rule_t  ent_s1;

	logic             a_hit_q, d_hit_q;
	logic [AW-1:0]    a_idx_q, d_idx_q;
	logic [7:0]       a_len_q, d_len_q;
	logic [15:0]      a_prio_q, d_prio_q;
	logic [1:0]       d_act_q;
	logic [AW-1:0]    win_q;

	logic [63:0]      pk_rd_q, by_rd_q;

	logic             rule_we, cnt_we, load_out;
	logic [AW-1:0]    cnt_ra, cnt_wa, q_addr, cur_addr;
	logic [63:0]      cnt_wpk, cnt_wby;
	logic             pick_deny;
	logic [AW-1:0]    pick_idx;

	logic [127:0]     mask, diff;
	logic             hit_s1;

	assign q_addr   = AW'(q_item.idx);
	assign cur_addr = AW'(cur_q.idx);

	// prefix compare of the rule read last cycle
	always_comb begin
		for (int j = 0; j < 128; j++) begin
			mask[127-j] = (j < int'(ent_s1.plen));
		end
		diff   = {cur_q.addr_hi, cur_q.addr_lo} ^ {ent_s1.hi, ent_s1.lo};
		hit_s1 = vld_s1 && written_q[idx_s1] && ent_s1.valid
			&& (ent_s1.fam == cur_q.fam) && ((diff & mask) == 128'd0);
	end

	// allow wins ties on priority
	assign pick_deny = d_hit_q && (!a_hit_q || (a_prio_q < d_prio_q));
	assign pick_idx  = pick_deny ? d_idx_q : a_idx_q;

	always_comb begin
		st_d     = state_q;
		q_pop    = 1'b0;
		rule_we  = 1'b0;
		cnt_we   = 1'b0;
		load_out = 1'b0;
		cnt_ra   = cur_addr;
		cnt_wa   = win_q;
		cnt_wpk  = pk_rd_q + 64'd1;
		cnt_wby  = by_rd_q + 64'(cur_q.pkt_len);
		case (state_q)
			cadf_pkg::ST_IDLE: begin
				cnt_ra = q_addr;
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_item.op)
						cadf_pkg::OP_CLASSIFY: begin
							st_d = q_item.is_ip ? cadf_pkg::ST_SCAN : cadf_pkg::ST_DONE;
						end
						cadf_pkg::OP_WRITE: begin
							rule_we = q_item.idx_ok;
							cnt_we  = q_item.idx_ok;
							cnt_wa  = q_addr;
							cnt_wpk = 64'd0;
							cnt_wby = 64'd0;
							st_d    = cadf_pkg::ST_DONE;
						end
						cadf_pkg::OP_READ: begin
							st_d = cadf_pkg::ST_READ;
						end
						default: begin
							st_d = cadf_pkg::ST_DONE;
						end
					endcase
				end
			end
			cadf_pkg::ST_SCAN: begin
				if (scan_q == LAST) begin
					st_d = cadf_pkg::ST_DRAIN;
				end
			end
			cadf_pkg::ST_DRAIN: begin
				st_d = cadf_pkg::ST_PICK;
			end
			cadf_pkg::ST_PICK: begin
				cnt_ra = pick_idx;
				st_d   = (a_hit_q || d_hit_q) ? cadf_pkg::ST_COUNT : cadf_pkg::ST_DONE;
			end
			cadf_pkg::ST_COUNT: begin
				cnt_we  = 1'b1;
				st_d    = cadf_pkg::ST_DONE;
			end
			cadf_pkg::ST_READ: begin
				st_d = cadf_pkg::ST_DONE;
			end
			cadf_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					st_d     = cadf_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = cadf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cadf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			written_q   <= '0;
			vld_s1      <= 1'b0;
			scan_q      <= '0;
			a_hit_q     <= 1'b0;
			d_hit_q     <= 1'b0;
		end else begin
			state_q <= st_d;
			vld_s1  <= (state_q == cadf_pkg::ST_SCAN);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (rule_we) begin
				written_q[q_addr] <= 1'b1;
			end
			if (state_q == cadf_pkg::ST_SCAN) begin
				scan_q <= scan_q + AW'(1);
			end else begin
				scan_q <= '0;
			end
			if (q_pop) begin
				a_hit_q <= 1'b0;
				d_hit_q <= 1'b0;
			end else if (hit_s1) begin
				if (!ent_s1.list && (!a_hit_q || ent_s1.plen > a_len_q)) begin
					a_hit_q <= 1'b1;
				end
				if (ent_s1.list && (!d_hit_q || ent_s1.plen > d_len_q)) begin
					d_hit_q <= 1'b1;
				end
			end
		end
	end

	// best-so-far payload; scan order makes the lowest index win ties
	always_ff @(posedge clk) begin
		if (hit_s1 && !ent_s1.list && (!a_hit_q || ent_s1.plen > a_len_q)) begin
			a_idx_q  <= idx_s1;
			a_len_q  <= ent_s1.plen;
			a_prio_q <= ent_s1.prio;
		end
		if (hit_s1 && ent_s1.list && (!d_hit_q || ent_s1.plen > d_len_q)) begin
			d_idx_q  <= idx_s1;
			d_len_q  <= ent_s1.plen;
			d_prio_q <= ent_s1.prio;
			d_act_q  <= ent_s1.act;
		end
		if (q_pop) begin
			cur_q <= q_item;
			res_q <= '0;
		end
		if (state_q == cadf_pkg::ST_PICK) begin
			win_q <= pick_idx;
			if (a_hit_q || d_hit_q) begin
				res_q.matched   <= pick_deny ? cadf_pkg::MATCH_DENY : cadf_pkg::MATCH_ALLOW;
				res_q.hit_index <= 6'(pick_idx);
				res_q.verdict   <= pick_deny && (d_act_q == cadf_pkg::ACT_DROP);
			end
		end
		if (state_q == cadf_pkg::ST_READ && cur_q.idx_ok && written_q[cur_addr]) begin
			res_q.count_packets <= pk_rd_q;
			res_q.count_bytes   <= by_rd_q;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	// rule table: one write port, one scan read port
	always_ff @(posedge clk) begin
		if (rule_we) begin
			rule_mem[q_addr] <= '{hi: q_item.addr_hi, lo: q_item.addr_lo,
				valid: q_item.rvalid, list: q_item.list, fam: q_item.rfam,
				plen: q_item.plen, prio: q_item.prio, act: q_item.act};
		end
		ent_s1 <= rule_mem[scan_q];
		idx_s1 <= scan_q;
	end

	// counters: registered read, then write back in the next cycle; a rule write clears them
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			pk_mem[cnt_wa] <= cnt_wpk;
			by_mem[cnt_wa] <= cnt_wby;
		end
		pk_rd_q <= pk_mem[cnt_ra];
		by_rd_q <= by_mem[cnt_ra];
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule
`default_nettype wire

FILE: hw/rtl/cidr_allow_deny_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Handshake              | Payload
// request | in_valid / in_ready    | opcode ethertype addr_hi addr_lo pkt_len rule_*
// result  | out_valid / out_ready  | verdict matched hit_index count_packets count_bytes
//
// Classify of an IP packet holds the back end while the rule table is swept one
// entry per cycle through its single read port; on a hit, the winner's counters
// then get a read and a write-back. Rule write, non-IP classify and unused opcode
// go straight to the result stage; a counter read first passes a read state.
// The request queue registers each accepted request before the back end takes it.
// Reset clears per-slot written flags at once; no clearing pass.
// A two-entry request queue lets the front accept while the back end works or
// the result register waits on out_ready.
module cidr_allow_deny_filter_core #(
	parameter int RULES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [15:0] ethertype,
	input  wire logic [63:0] addr_hi,
	input  wire logic [63:0] addr_lo,
	input  wire logic [15:0] pkt_len,
	input  wire logic [5:0]  rule_index,
	input  wire logic        rule_list,
	input  wire logic        rule_family,
	input  wire logic [7:0]  rule_prefix_len,
	input  wire logic [15:0] rule_priority,
	input  wire logic [1:0]  rule_action,
	input  wire logic        rule_valid,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             verdict,
	output logic [1:0]       matched,
	output logic [5:0]       hit_index,
	output logic [63:0]      count_packets,
	output logic [63:0]      count_bytes
);

	logic           q_valid;
	logic           q_pop;
	cadf_pkg::req_t q_item;
	cadf_pkg::res_t res;

	// front: decode request, hold up to two in queue
	cadf_front #(.RULES(RULES)) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.ethertype       (ethertype),
		.addr_hi         (addr_hi),
		.addr_lo         (addr_lo),
		.pkt_len         (pkt_len),
		.rule_index      (rule_index),
		.rule_list       (rule_list),
		.rule_family     (rule_family),
		.rule_prefix_len (rule_prefix_len),
		.rule_priority   (rule_priority),
		.rule_action     (rule_action),
		.rule_valid      (rule_valid),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.q_pop           (q_pop)
	);

	// back: table sweep, winner pick, counter update, result register
	cadf_back #(.RULES(RULES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res)
	);

	assign verdict       = res.verdict;
	assign matched       = res.matched;
	assign hit_index     = res.hit_index;
	assign count_packets = res.count_packets;
	assign count_bytes   = res.count_bytes;

endmodule
`default_nettype wire

FILE: tb/cidr_allow_deny_filter_core_test.sv
`timescale 1ns / 1ps
module cidr_allow_deny_filter_core_test;

	localparam int N_RULES = 64;

	// one request as it is put on the input port
	typedef struct {
		logic [1:0]  op;
		logic [15:0] eth;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [15:0] len;
		logic [5:0]  idx;
		logic        list;
		logic        fam;
		logic [7:0]  plen;
		logic [15:0] prio;
		logic [1:0]  act;
		logic        valid;
	} filt_req_t;

	// directed row: a request plus an optional typed-in answer
	typedef struct {
		filt_req_t      req;
		bit             typed;
		cadf_pkg::res_t res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  opcode;
	logic [15:0] ethertype;
	logic [63:0] addr_hi;
	logic [63:0] addr_lo;
	logic [15:0] pkt_len;
	logic [5:0]  rule_index;
	logic        rule_list;
	logic        rule_family;
	logic [7:0]  rule_prefix_len;
	logic [15:0] rule_priority;
	logic [1:0]  rule_action;
	logic        rule_valid;
	logic        out_valid;
	logic        out_ready;
	logic        verdict;
	logic [1:0]  matched;
	logic [5:0]  hit_index;
	logic [63:0] count_packets;
	logic [63:0] count_bytes;

	cidr_allow_deny_filter_core #(.RULES(N_RULES)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .ethertype(ethertype), .addr_hi(addr_hi), .addr_lo(addr_lo),
		.pkt_len(pkt_len), .rule_index(rule_index), .rule_list(rule_list),
		.rule_family(rule_family), .rule_prefix_len(rule_prefix_len),
		.rule_priority(rule_priority), .rule_action(rule_action), .rule_valid(rule_valid),
		.out_valid(out_valid), .out_ready(out_ready),
		.verdict(verdict), .matched(matched), .hit_index(hit_index),
		.count_packets(count_packets), .count_bytes(count_bytes)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// shadow copy of the rule table and its counters
	cadf_pkg::rule_t shadow_rules[N_RULES];
	logic [63:0]     shadow_pkts[N_RULES];
	logic [63:0]     shadow_bytes[N_RULES];

	cadf_pkg::res_t expected_results[$];
	int   n_errors = 0;

	// idle knobs, in percent: send side per accepted request, result side per cycle
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_reqs = 0;	// bumped by the stimulus to ask for a long out_ready hold

	function automatic logic [63:0] upper_mask(int unsigned plen);
		if (plen == 0) return 64'd0;
		if (plen >= 64) return '1;
		return ~64'd0 << (64 - plen);
	endfunction

	function automatic logic [63:0] lower_mask(int unsigned plen);
		if (plen <= 64) return 64'd0;
		if (plen >= 128) return '1;
		return ~64'd0 << (128 - plen);
	endfunction

	// longest valid matching prefix in one list; lowest index on ties; -1 when none
	function automatic int longest_match(logic list, logic fam, logic [63:0] hi,
			logic [63:0] lo);
		int best;
		int best_len;
		best = -1;
		best_len = 0;
		for (int i = 0; i < N_RULES; i++) begin
			if (!shadow_rules[i].valid || shadow_rules[i].list != list ||
					shadow_rules[i].fam != fam)
				continue;
			if (((hi ^ shadow_rules[i].hi) & upper_mask(shadow_rules[i].plen)) != 0)
				continue;
			if (((lo ^ shadow_rules[i].lo) & lower_mask(shadow_rules[i].plen)) != 0)
				continue;
			if (best < 0 || int'(shadow_rules[i].plen) > best_len) begin
				best = i;
				best_len = shadow_rules[i].plen;
			end
		end
		return best;
	endfunction

	// applies one request to the shadow table and returns what the block must answer
	function automatic cadf_pkg::res_t filter_outcome(filt_req_t r);
		cadf_pkg::res_t o;
		logic fam;
		logic [63:0] hi;
		logic [63:0] lo;
		int a;
		int d;
		int win;
		logic deny_wins;
		logic [7:0] cap;
		o = '0;
		hi = r.hi;
		lo = r.lo;
		case (r.op)
			cadf_pkg::OP_CLASSIFY: begin
				if (r.eth == cadf_pkg::ETH_IPV4) begin
					fam = 1'b0;
					hi = {hi[63:32], 32'd0};
					lo = '0;
				end else if (r.eth == cadf_pkg::ETH_IPV6) begin
					fam = 1'b1;
				end else begin
					return o;	// non-IP passes untouched
				end
				a = longest_match(1'b0, fam, hi, lo);
				d = longest_match(1'b1, fam, hi, lo);
				if (a < 0 && d < 0)
					return o;
				if (a >= 0 && d >= 0)
					deny_wins = !(shadow_rules[a].prio >= shadow_rules[d].prio);
				else
					deny_wins = (d >= 0);
				win = deny_wins ? d : a;
				shadow_pkts[win] += 64'd1;
				shadow_bytes[win] += 64'(r.len);
				o.matched = deny_wins ? cadf_pkg::MATCH_DENY : cadf_pkg::MATCH_ALLOW;
				o.hit_index = 6'(win);
				o.verdict = deny_wins && (shadow_rules[win].act == cadf_pkg::ACT_DROP);
			end
			cadf_pkg::OP_WRITE: begin
				cap = r.fam ? cadf_pkg::LEN_V6 : cadf_pkg::LEN_V4;
				shadow_rules[r.idx].hi = r.hi;
				shadow_rules[r.idx].lo = r.lo;
				shadow_rules[r.idx].valid = r.valid;
				shadow_rules[r.idx].list = r.list;
				shadow_rules[r.idx].fam = r.fam;
				shadow_rules[r.idx].plen = (r.plen > cap) ? cap : r.plen;
				shadow_rules[r.idx].prio = r.prio;
				shadow_rules[r.idx].act = r.act;
				shadow_pkts[r.idx] = '0;
				shadow_bytes[r.idx] = '0;
			end
			cadf_pkg::OP_READ: begin
				o.count_packets = shadow_pkts[r.idx];
				o.count_bytes = shadow_bytes[r.idx];
			end
			default: ;	// unused opcode: all-zero answer
		endcase
		return o;
	endfunction

	// puts one request on the port and holds it until taken
	task automatic offer(filt_req_t r, bit typed, cadf_pkg::res_t typed_res);
		cadf_pkg::res_t p;
		opcode <= r.op;
		ethertype <= r.eth;
		addr_hi <= r.hi;
		addr_lo <= r.lo;
		pkt_len <= r.len;
		rule_index <= r.idx;
		rule_list <= r.list;
		rule_family <= r.fam;
		rule_prefix_len <= r.plen;
		rule_priority <= r.prio;
		rule_action <= r.act;
		rule_valid <= r.valid;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		p = filter_outcome(r);	// shadow state moves even for typed rows
		expected_results.push_back(typed ? typed_res : p);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic filt_req_t blank_req();
		filt_req_t r;
		r = '{op: cadf_pkg::OP_CLASSIFY, eth: cadf_pkg::ETH_IPV4, hi: '0, lo: '0,
			len: '0, idx: '0, list: 1'b0, fam: 1'b0, plen: '0, prio: '0, act: '0,
			valid: 1'b0};
		return r;
	endfunction

	function automatic filt_req_t wr_rule(logic [5:0] idx, logic list, logic fam,
			logic [63:0] hi, logic [63:0] lo, logic [7:0] plen, logic [15:0] prio,
			logic [1:0] act, logic valid);
		filt_req_t r;
		r = blank_req();
		r.op = cadf_pkg::OP_WRITE;
		r.idx = idx; r.list = list; r.fam = fam; r.hi = hi; r.lo = lo;
		r.plen = plen; r.prio = prio; r.act = act; r.valid = valid;
		return r;
	endfunction

	function automatic filt_req_t pkt(logic [15:0] eth, logic [63:0] hi, logic [63:0] lo,
			logic [15:0] len);
		filt_req_t r;
		r = blank_req();
		r.eth = eth; r.hi = hi; r.lo = lo; r.len = len;
		return r;
	endfunction

	function automatic filt_req_t rd_rule(logic [5:0] idx);
		filt_req_t r;
		r = blank_req();
		r.op = cadf_pkg::OP_READ;
		r.idx = idx;
		return r;
	endfunction

	// a few base prefixes so random rules overlap and packets actually hit
	logic [63:0] base_hi[4] = '{64'h0A00_0000_0000_0000, 64'hC0A8_0100_0000_0000,
		64'h2001_0DB8_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF};
	logic [63:0] base_lo[4] = '{64'h0, 64'h1234_5678_9ABC_DEF0, 64'hFFFF_FFFF_0000_0000,
		64'hFFFF_FFFF_FFFF_FFFF};

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] near(logic [63:0] b);
		// keep the top bits of the base, scramble a random number of low bits
		return b ^ (rand64() >> $urandom_range(0, 64));
	endfunction

	// random request: mostly rule writes and packets aimed at the rules' prefixes
	function automatic filt_req_t random_req();
		filt_req_t r;
		int k;
		int sel;
		int j;
		r = blank_req();
		k = $urandom_range(0, 99);
		sel = $urandom_range(0, 3);
		j = $urandom_range(0, N_RULES - 1);
		r.len = 16'($urandom);
		r.idx = 6'($urandom);
		r.list = 1'($urandom);
		r.fam = 1'($urandom);
		r.prio = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
		r.act = 2'($urandom);
		r.valid = ($urandom_range(0, 9) != 0);
		if (k < 20) begin
			r.op = cadf_pkg::OP_WRITE;
			r.idx = 6'($urandom_range(0, 15));	// keep the live table small
			r.hi = near(base_hi[sel]);
			r.lo = near(base_lo[sel]);
			case ($urandom_range(0, 5))
				0: r.plen = 8'($urandom);
				1: r.plen = 8'd0;
				default: r.plen = r.fam ? 8'($urandom_range(0, 128)) : 8'($urandom_range(0, 32));
			endcase
		end else if (k < 85) begin
			r.op = cadf_pkg::OP_CLASSIFY;
			case ($urandom_range(0, 9))
				0: r.eth = 16'($urandom);
				1, 2, 3, 4: r.eth = cadf_pkg::ETH_IPV4;
				default: r.eth = cadf_pkg::ETH_IPV6;
			endcase
			if ($urandom_range(0, 3) == 0) begin
				r.hi = rand64();
				r.lo = rand64();
			end else if ($urandom_range(0, 1) == 0) begin
				r.hi = near(shadow_rules[j].hi);
				r.lo = near(shadow_rules[j].lo);
			end else begin
				r.hi = near(base_hi[sel]);
				r.lo = near(base_lo[sel]);
			end
		end else if (k < 97) begin
			r.op = cadf_pkg::OP_READ;
			r.idx = 6'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 15));
		end else begin
			r.op = cadf_pkg::OP_NONE;
			r.hi = rand64();
			r.lo = rand64();
			r.eth = 16'($urandom);
		end
		return r;
	endfunction

	// result side: random back-pressure, plus a long hold when asked
	int hold_left = 0;
	int hold_seen = 0;
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		cadf_pkg::res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result verdict=%0d matched=%0d hit=%0d",
					$time, verdict, matched, hit_index);
				n_errors++;
			end else begin
				e = expected_results.pop_front();
				if (verdict !== e.verdict) begin
					$display("%0t: verdict exp %0d got %0d", $time, e.verdict, verdict);
					n_errors++;
				end
				if (matched !== e.matched) begin
					$display("%0t: matched exp %0d got %0d", $time, e.matched, matched);
					n_errors++;
				end
				if (hit_index !== e.hit_index) begin
					$display("%0t: hit_index exp %0d got %0d", $time, e.hit_index, hit_index);
					n_errors++;
				end
				if (count_packets !== e.count_packets) begin
					$display("%0t: count_packets exp %h got %h", $time, e.count_packets,
						count_packets);
					n_errors++;
				end
				if (count_bytes !== e.count_bytes) begin
					$display("%0t: count_bytes exp %h got %h", $time, e.count_bytes, count_bytes);
					n_errors++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	stim_row_t directed[$];

	initial begin
		cadf_pkg::res_t zero_res;
		filt_req_t r;
		zero_res = '0;
		for (int i = 0; i < N_RULES; i++) begin
			shadow_rules[i] = '0;
			shadow_pkts[i] = '0;
			shadow_bytes[i] = '0;
		end
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		out_ready <= 1'b0;
		r = blank_req();
		opcode <= r.op; ethertype <= r.eth; addr_hi <= '0; addr_lo <= '0; pkt_len <= '0;
		rule_index <= '0; rule_list <= 1'b0; rule_family <= 1'b0; rule_prefix_len <= '0;
		rule_priority <= '0; rule_action <= '0; rule_valid <= 1'b0;

		// empty table: everything passes, counts nothing
		directed.push_back('{pkt(cadf_pkg::ETH_IPV4, '1, '1, 16'hFFFF), 1, zero_res});
		directed.push_back('{pkt(cadf_pkg::ETH_IPV6, '1, '1, 16'hFFFF), 1, zero_res});
		directed.push_back('{rd_rule(6'd63), 1, zero_res});
		r = blank_req(); r.op = cadf_pkg::OP_NONE; r.hi = '1; r.lo = '1; r.eth = '1;
		r.idx = '1;
		directed.push_back('{r, 1, zero_res});
		// overlapping v4 allow /8 and deny /16, equal priority: allow wins the tie
		directed.push_back('{wr_rule(6'd0, 1'b0, 1'b0, 64'h0A00_0000_0000_0000, '0,
			8'd8, 16'd5, 2'd0, 1'b1), 1, zero_res});
		directed.push_back('{wr_rule(6'd1, 1'b1, 1'b0, 64'h0A01_0000_0000_0000, '0,
			8'd16, 16'd5, cadf_pkg::ACT_DROP, 1'b1), 1, zero_res});
		directed.push_back('{pkt(cadf_pkg::ETH_IPV4, 64'h0A01_0203_FFFF_FFFF, '1,
			16'd100), 0, zero_res});
		// deny /24 at higher priority now drops
		directed.push_back('{wr_rule(6'd2, 1'b1, 1'b0, 64'h0A01_0200_0000_0000, '0,
			8'd24, 16'd6, cadf_pkg::ACT_DROP, 1'b1), 1, zero_res});
		directed.push_back('{pkt(cadf_pkg::ETH_IPV4, 64'h0A01_0203_0000_0000, '0,
			16'hFFFF), 0, zero_res});
		// deny winner with a non-drop action passes
		directed.push_back('{wr_rule(6'd5, 1'b1, 1'b0, 64'h0A01_0209_0000_0000, '0,
			8'd32, 16'hFFFF, 2'd3, 1'b1), 1, zero_res});
		directed.push_back('{pkt(cadf_pkg::ETH_IPV4, 64'h0A01_0209_1234_5678, '0,
			16'd1), 0, zero_res});
		// overlong prefixes saturate
		directed.push_back('{wr_rule(6'd3, 1'b0, 1'b0, 64'hC0A8_0101_0000_0000, '0,
			8'hFF, 16'hFFFF, 2'd2, 1'b1), 1, zero_res});
		directed.push_back('{wr_rule(6'd63, 1'b1, 1'b1, '1, '1,
			8'd200, 16'd0, cadf_pkg::ACT_DROP, 1'b1), 1, zero_res});
		directed.push_back('{pkt(cadf_pkg::ETH_IPV4, 64'hC0A8_0101_0000_0000, '0,
			16'd0), 0, zero_res});
		directed.push_back('{pkt(cadf_pkg::ETH_IPV6, '1, '1, 16'd64), 0, zero_res});
		directed.push_back('{pkt(cadf_pkg::ETH_IPV6, '1, 64'hFFFF_FFFF_FFFF_FFFE,
			16'd64), 0, zero_res});
		// zero-length v6 allow catches the rest of v6
		directed.push_back('{wr_rule(6'd4, 1'b0, 1'b1, '1, '1,
			8'd0, 16'd0, 2'd0, 1'b1), 1, zero_res});
		directed.push_back('{pkt(cadf_pkg::ETH_IPV6, '0, '0, 16'd7), 0, zero_res});
		// non-IP passes and counts nothing
		directed.push_back('{pkt(16'hFFFF, 64'h0A01_0203_0000_0000, '0, 16'd9), 1, zero_res});
		directed.push_back('{pkt(16'h0000, '0, '0, 16'd9), 1, zero_res});
		// disabling a slot, then counter reads
		directed.push_back('{wr_rule(6'd2, 1'b1, 1'b0, 64'h0A01_0200_0000_0000, '0,
			8'd24, 16'd6, cadf_pkg::ACT_DROP, 1'b0), 1, zero_res});
		directed.push_back('{pkt(cadf_pkg::ETH_IPV4, 64'h0A01_0203_0000_0000, '0,
			16'd3), 0, zero_res});
		directed.push_back('{rd_rule(6'd0), 0, zero_res});
		directed.push_back('{rd_rule(6'd63), 0, zero_res});
		directed.push_back('{rd_rule(6'd2), 1, zero_res});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			offer(directed[i].req, directed[i].typed, directed[i].res);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			if (phase == 0)
				hold_reqs++;	// long stall on results while requests keep coming
			for (int n = 0; n < 160; n++)
				offer(random_req(), 0, zero_res);
		end
		in_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: cidr_allow_deny_filter_core.f
hw/rtl/cadf_pkg.sv
hw/rtl/cadf_front.sv
hw/rtl/cadf_back.sv
hw/rtl/cidr_allow_deny_filter_core.sv
tb/cidr_allow_deny_filter_core_test.sv
